// ===== rtl/fdnr_pkg.sv =====
// Package for the feedback delay network reverb: register map, reset values,
// tap lengths and fixed widths shared by the RTL modules.
// No dependencies.
`timescale 1ns / 1ps

package fdnr_pkg;

    localparam int DEF_LINE_COUNT  = 8;
    localparam int DEF_LINE_DEPTH  = 32768;
    localparam int DEF_SAMPLE_BITS = 24;

    localparam int COEF_W  = 24;
    localparam int GAIN_W  = 16;
    localparam int HIST_W  = 32;
    localparam int APB_W   = 32;
    localparam int PADDR_W = 5;
    localparam int REG_IDX_W = 3;

    localparam logic [REG_IDX_W-1:0] REG_WET_MIX       = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_FEEDBACK_GAIN = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_DAMP_B0       = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_DAMP_B1       = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_DAMP_A1       = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_DAMP_A2       = 3'd5;

    localparam logic [GAIN_W-1:0] RST_WET_MIX       = 16'd5898;
    localparam logic [GAIN_W-1:0] RST_FEEDBACK_GAIN = 16'd27525;
    localparam logic [COEF_W-1:0] RST_DAMP_B0       = 24'd260587;
    localparam logic [COEF_W-1:0] RST_DAMP_B1       = 24'd521175;
    localparam logic [COEF_W-1:0] RST_DAMP_A1       = 24'd11820806;
    localparam logic [COEF_W-1:0] RST_DAMP_A2       = 24'd1804477;

    // unity in Q1.15, one bit wider than the gain registers
    localparam logic [GAIN_W:0] UNITY_GAIN = 17'd32768;

    localparam int TAP_W     = 15;
    localparam int TAP_IDX_W = 3;
    localparam logic [TAP_W-1:0] TAP_LEN [8] = '{
        15'd10691, 15'd11777, 15'd12983, 15'd14197,
        15'd15401, 15'd16573, 15'd17749, 15'd18947
    };

    // items written so far, saturating at FILL_MAX, which lies above every tap length
    localparam int FILL_W = 16;
    localparam logic [FILL_W-1:0] FILL_MAX = 16'd32768;

endpackage

// ===== rtl/feedback_delay_network_reverb.sv =====
// Feedback delay network reverb top level: APB registers, sequencer, damper
// pipeline and feedback writer around the delay and damper-history RAMs.
// Depends on fdnr_pkg, fdnr_ram and fdnr_avg.
//
// Usage:
//   s_tvalid/s_tready/s_tdata take one dry sample per item; m_tvalid/m_tready/
//   m_tdata return one mixed sample per item. Registers sit on the APB port at
//   byte address 4*index; pready is always high. Write them only while idle.
//   An item runs through: tap pass (one line issued per cycle, then a
//   pipeline drain), average (a shift for a power-of-two line count, a
//   restoring divide otherwise), feedback pass and output load. The next item
//   can be accepted in the cycle in which m_tvalid rises. The one-port-pair
//   delay RAM and the sequential line passes mean that a new item is taken only
//   once the last one has been loaded into the output register.
//   The result waits in an output register; a new item is accepted while it
//   waits, and only the final load stalls until the receiver takes it.
//   Reset returns the registers to their defaults and clears the damper-history valid flags; the
//   delay RAM needs no clearing pass: a fill count masks taps not yet written.
`timescale 1ns / 1ps

module feedback_delay_network_reverb
    import fdnr_pkg::*;
#(
    parameter int LINE_COUNT  = DEF_LINE_COUNT,
    parameter int LINE_DEPTH  = DEF_LINE_DEPTH,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]     s_tdata,   // in_sample
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]     m_tdata,   // out_sample
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [PADDR_W-1:0]                   paddr,
    input  logic [APB_W-1:0]                     pwdata,
    output logic [APB_W-1:0]                     prdata,
    output logic                                 pready
);

    localparam int S       = SAMPLE_BITS;
    localparam int DATA_W  = ((S + 7) / 8) * 8;
    localparam int LINE_W  = $clog2(LINE_COUNT);
    localparam int PTR_W   = $clog2(LINE_DEPTH);
    localparam int DADDR_W = LINE_W + PTR_W;
    localparam int SUM_W   = S + 3;
    localparam int SW      = ((S + 3 > HIST_W) ? S + 3 : HIST_W) + 2;
    localparam int CPW     = S + COEF_W;
    localparam int GW      = GAIN_W + 2;
    localparam int FPW     = S + 1 + GW;
    localparam int MPW     = S + GW;
    localparam int MSW     = MPW + 1;

    localparam logic signed [SW-1:0] S_MAX = SW'({1'b0, {(S-1){1'b1}}});
    localparam logic signed [SW-1:0] S_MIN = ~S_MAX;
    localparam logic signed [SW-1:0] H_MAX = SW'({1'b0, {(HIST_W-1){1'b1}}});
    localparam logic signed [SW-1:0] H_MIN = ~H_MAX;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_TAPS  = 3'd1;
    localparam logic [2:0] ST_DRAIN = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_FEED  = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    function automatic logic signed [S-1:0] sat_s(input logic signed [SW-1:0] v);
        if (v > S_MAX)
            return S_MAX[S-1:0];
        else if (v < S_MIN)
            return S_MIN[S-1:0];
        else
            return v[S-1:0];
    endfunction

    function automatic logic signed [HIST_W-1:0] sat_h(input logic signed [SW-1:0] v);
        if (v > H_MAX)
            return H_MAX[HIST_W-1:0];
        else if (v < H_MIN)
            return H_MIN[HIST_W-1:0];
        else
            return v[HIST_W-1:0];
    endfunction

    function automatic logic signed [S+1:0] rnd22(input logic signed [CPW-1:0] p);
        logic signed [CPW-1:0] t;
        t = p + CPW'(2**21);
        return $signed(t[CPW-1:22]);
    endfunction

    // ---------------------------------------------------------------- registers
    logic [GAIN_W-1:0] wet_mix_reg;
    logic [GAIN_W-1:0] feedback_gain_reg;
    logic [COEF_W-1:0] damp_b0_reg;
    logic [COEF_W-1:0] damp_b1_reg;
    logic [COEF_W-1:0] damp_a1_reg;
    logic [COEF_W-1:0] damp_a2_reg;
    logic              cfg_we;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wet_mix_reg       <= RST_WET_MIX;
            feedback_gain_reg <= RST_FEEDBACK_GAIN;
            damp_b0_reg       <= RST_DAMP_B0;
            damp_b1_reg       <= RST_DAMP_B1;
            damp_a1_reg       <= RST_DAMP_A1;
            damp_a2_reg       <= RST_DAMP_A2;
        end
        else if (cfg_we)
        begin
            unique case (paddr[PADDR_W-1:2])
                REG_WET_MIX:       wet_mix_reg       <= pwdata[GAIN_W-1:0];
                REG_FEEDBACK_GAIN: feedback_gain_reg <= pwdata[GAIN_W-1:0];
                REG_DAMP_B0:       damp_b0_reg       <= pwdata[COEF_W-1:0];
                REG_DAMP_B1:       damp_b1_reg       <= pwdata[COEF_W-1:0];
                REG_DAMP_A1:       damp_a1_reg       <= pwdata[COEF_W-1:0];
                REG_DAMP_A2:       damp_a2_reg       <= pwdata[COEF_W-1:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[PADDR_W-1:2])
            REG_WET_MIX:       prdata = APB_W'(wet_mix_reg);
            REG_FEEDBACK_GAIN: prdata = APB_W'(feedback_gain_reg);
            REG_DAMP_B0:       prdata = APB_W'(damp_b0_reg);
            REG_DAMP_B1:       prdata = APB_W'(damp_b1_reg);
            REG_DAMP_A1:       prdata = APB_W'(damp_a1_reg);
            REG_DAMP_A2:       prdata = APB_W'(damp_a2_reg);
            default:           prdata = '0;
        endcase
    end

    logic signed [COEF_W-1:0] b0;
    logic signed [COEF_W-1:0] b1;
    logic signed [COEF_W-1:0] a1;
    logic signed [COEF_W-1:0] a2;
    logic [GAIN_W:0]          wet_g;
    logic [GAIN_W:0]          fbg_g;
    logic signed [GW-1:0]     wet_s;
    logic signed [GW-1:0]     dry_s;
    logic signed [GW-1:0]     fbg_s;

    assign b0 = $signed(damp_b0_reg);
    assign b1 = $signed(damp_b1_reg);
    assign a1 = $signed(damp_a1_reg);
    assign a2 = $signed(damp_a2_reg);
    assign wet_g = ((GAIN_W + 1)'(wet_mix_reg) > UNITY_GAIN) ? UNITY_GAIN
                                                              : (GAIN_W + 1)'(wet_mix_reg);
    assign fbg_g = ((GAIN_W + 1)'(feedback_gain_reg) > UNITY_GAIN)
                   ? UNITY_GAIN : (GAIN_W + 1)'(feedback_gain_reg);
    assign wet_s = $signed({1'b0, wet_g});
    assign dry_s = $signed({1'b0, UNITY_GAIN - wet_g});
    assign fbg_s = $signed({1'b0, fbg_g});

    // ---------------------------------------------------------------- sequencer
    logic [2:0]        state_reg;
    logic [2:0]        state_next;
    logic [LINE_W-1:0] idx_reg;
    logic              idx_last;
    logic [PTR_W-1:0]  wp_reg;
    logic [FILL_W-1:0] fill_reg;
    logic              m_tvalid_reg;
    logic              out_free;
    logic              out_load;
    logic              pipe_busy;
    logic              div_start;
    logic              div_done;
    logic              in_accept;

    logic              s1_vld_reg, s2_vld_reg, s3_vld_reg, s4_vld_reg;
    logic              fb_vld_reg;
    logic [LINE_COUNT-1:0] hvalid_reg;

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign idx_last  = (idx_reg == LINE_W'(LINE_COUNT - 1));
    assign out_free  = !m_tvalid_reg || m_tready;
    assign out_load  = (state_reg == ST_OUT) && out_free;
    assign pipe_busy = s1_vld_reg || s2_vld_reg || s3_vld_reg || s4_vld_reg;
    assign div_start = (state_reg == ST_DRAIN) && !pipe_busy;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (in_accept) state_next = ST_TAPS;
            ST_TAPS:  if (idx_last) state_next = ST_DRAIN;
            ST_DRAIN: if (!pipe_busy) state_next = ST_DIV;
            ST_DIV:   if (div_done) state_next = ST_FEED;
            ST_FEED:  if (idx_last) state_next = ST_OUT;
            ST_OUT:   if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            idx_reg      <= '0;
            wp_reg       <= '0;
            fill_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if ((state_reg == ST_TAPS) || (state_reg == ST_FEED))
            begin
                idx_reg <= idx_last ? '0 : idx_reg + 1'b1;
            end
            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
                wp_reg <= (wp_reg == PTR_W'(LINE_DEPTH - 1)) ? '0 : wp_reg + 1'b1;
                if (fill_reg < FILL_MAX)
                begin
                    fill_reg <= fill_reg + 1'b1;
                end
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------- memories
    logic               dly_we;
    logic [DADDR_W-1:0] dly_waddr;
    logic [S-1:0]       dly_wdata;
    logic [DADDR_W-1:0] dly_raddr;
    logic [S-1:0]       dly_rdata;
    logic               hist_we;
    logic [LINE_W-1:0]  hist_waddr;
    logic [2*HIST_W-1:0] hist_wdata;
    logic [2*HIST_W-1:0] hist_rdata;

    fdnr_ram #(
        .WIDTH (S),
        .DEPTH (LINE_COUNT << PTR_W)
    ) u_delay_ram (
        .clk   (clk),
        .we    (dly_we),
        .waddr (dly_waddr),
        .wdata (dly_wdata),
        .raddr (dly_raddr),
        .rdata (dly_rdata)
    );

    fdnr_ram #(
        .WIDTH (2 * HIST_W),
        .DEPTH (LINE_COUNT)
    ) u_hist_ram (
        .clk   (clk),
        .we    (hist_we),
        .waddr (hist_waddr),
        .wdata (hist_wdata),
        .raddr (idx_reg),
        .rdata (hist_rdata)
    );

    // ---------------------------------------------------------------- tap pass
    logic [TAP_W-1:0] tap_len;
    logic [PTR_W:0]   rp_wide;
    logic [PTR_W:0]   rp_wrap;
    logic [PTR_W-1:0] rp;
    logic             issue;

    assign issue   = (state_reg == ST_TAPS);
    assign tap_len = TAP_LEN[TAP_IDX_W'(idx_reg)];
    assign rp_wide = (PTR_W + 1)'(wp_reg) + (PTR_W + 1)'(LINE_DEPTH) - (PTR_W + 1)'(tap_len);
    assign rp_wrap = (rp_wide >= (PTR_W + 1)'(LINE_DEPTH)) ? rp_wide - (PTR_W + 1)'(LINE_DEPTH)
                                                           : rp_wide;
    assign rp        = rp_wrap[PTR_W-1:0];
    assign dly_raddr = {idx_reg, rp};

    logic [LINE_W-1:0] s1_line_reg, s2_line_reg, s3_line_reg, s4_line_reg;
    logic              s1_tapok_reg;
    logic              s1_hok_reg;
    logic signed [S-1:0]      s1_x;
    logic signed [HIST_W-1:0] s1_z1;
    logic signed [HIST_W-1:0] s1_z2;
    logic signed [CPW-1:0]    s2_pb0_reg, s2_pb1_reg;
    logic signed [HIST_W-1:0] s2_z1_reg, s2_z2_reg;
    logic signed [S+1:0]      s2_fx0, s2_rb1;
    logic signed [S-1:0]      s2_y;
    logic signed [S-1:0]      s3_y_reg;
    logic signed [S+1:0]      s3_fx0_reg, s3_rb1_reg, s4_fx0_reg, s4_rb1_reg;
    logic signed [HIST_W-1:0] s3_z2_reg, s4_z2_reg;
    logic signed [CPW-1:0]    s4_pa1_reg, s4_pa2_reg;
    logic signed [HIST_W-1:0] s4_n1, s4_n2;
    logic signed [SUM_W-1:0]  sum_reg;
    logic signed [S-1:0]      taps_reg [LINE_COUNT];
    logic signed [S-1:0]      x_in_reg;

    assign s1_x  = s1_tapok_reg ? $signed(dly_rdata) : '0;
    assign s1_z1 = s1_hok_reg ? $signed(hist_rdata[HIST_W-1:0]) : '0;
    assign s1_z2 = s1_hok_reg ? $signed(hist_rdata[2*HIST_W-1:HIST_W]) : '0;

    assign s2_fx0 = rnd22(s2_pb0_reg);
    assign s2_rb1 = rnd22(s2_pb1_reg);
    assign s2_y   = sat_s(SW'(s2_fx0) + SW'(s2_z1_reg));

    assign s4_n1 = sat_h(SW'(s4_rb1_reg) - SW'(rnd22(s4_pa1_reg)) + SW'(s4_z2_reg));
    assign s4_n2 = sat_h(SW'(s4_fx0_reg) - SW'(rnd22(s4_pa2_reg)));

    assign hist_we    = s4_vld_reg;
    assign hist_waddr = s4_line_reg;
    assign hist_wdata = {s4_n2, s4_n1};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
            fb_vld_reg <= 1'b0;
            hvalid_reg <= '0;
        end
        else
        begin
            s1_vld_reg <= issue;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            s4_vld_reg <= s3_vld_reg;
            fb_vld_reg <= (state_reg == ST_FEED);
            if (s4_vld_reg)
            begin
                hvalid_reg[s4_line_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            x_in_reg <= $signed(s_tdata[S-1:0]);
        end
        s1_line_reg  <= idx_reg;
        s1_tapok_reg <= (fill_reg >= FILL_W'(tap_len));
        s1_hok_reg   <= hvalid_reg[idx_reg];

        s2_pb0_reg  <= b0 * s1_x;
        s2_pb1_reg  <= b1 * s1_x;
        s2_z1_reg   <= s1_z1;
        s2_z2_reg   <= s1_z2;
        s2_line_reg <= s1_line_reg;

        s3_y_reg    <= s2_y;
        s3_fx0_reg  <= s2_fx0;
        s3_rb1_reg  <= s2_rb1;
        s3_z2_reg   <= s2_z2_reg;
        s3_line_reg <= s2_line_reg;

        s4_pa1_reg  <= a1 * s3_y_reg;
        s4_pa2_reg  <= a2 * s3_y_reg;
        s4_fx0_reg  <= s3_fx0_reg;
        s4_rb1_reg  <= s3_rb1_reg;
        s4_z2_reg   <= s3_z2_reg;
        s4_line_reg <= s3_line_reg;

        if (in_accept)
        begin
            sum_reg <= '0;
        end
        else if (s3_vld_reg)
        begin
            sum_reg <= sum_reg + SUM_W'(s3_y_reg);
            taps_reg[s3_line_reg] <= s3_y_reg;
        end
    end

    // ---------------------------------------------------------------- average
    logic signed [S-1:0] avg;

    fdnr_avg #(
        .LINE_COUNT  (LINE_COUNT),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_avg (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .sum   (sum_reg),
        .avg   (avg),
        .done  (div_done)
    );

    // ---------------------------------------------------------------- feedback
    logic signed [S:0]       fb_diff;
    logic signed [FPW-1:0]   fb_prod_reg;
    logic [LINE_W-1:0]       fb_line_reg;
    logic signed [FPW-1:0]   fb_t;
    logic signed [S+3:0]     fb_r;

    assign fb_diff = (S + 1)'(taps_reg[idx_reg]) - (S + 1)'(avg);
    assign fb_t    = fb_prod_reg + FPW'(2**14);
    assign fb_r    = $signed(fb_t[FPW-1:15]);

    assign dly_we    = fb_vld_reg;
    assign dly_waddr = {fb_line_reg, wp_reg};
    assign dly_wdata = sat_s(SW'(x_in_reg) + SW'(fb_r));

    // ---------------------------------------------------------------- output mix
    logic signed [MPW-1:0] mix_dry_reg;
    logic signed [MPW-1:0] mix_wet_reg;
    logic signed [MSW-1:0] mix_t;
    logic signed [S+3:0]   mix_r;
    logic [S-1:0]          out_reg;

    assign mix_t = MSW'(mix_dry_reg) + MSW'(mix_wet_reg) + MSW'(2**14);
    assign mix_r = $signed(mix_t[MSW-1:15]);

    always_ff @(posedge clk)
    begin
        fb_prod_reg <= fb_diff * fbg_s;
        fb_line_reg <= idx_reg;
        mix_dry_reg <= x_in_reg * dry_s;
        mix_wet_reg <= avg * wet_s;
        if (out_load)
        begin
            out_reg <= sat_s(SW'(mix_r));
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = DATA_W'(out_reg);

    // ---------------------------------------------------------------- checks
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (state_reg == ST_TAPS))
        else $error("accepted item did not start the tap pass");

    a_load_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> ($past(state_reg) == ST_OUT))
        else $error("result loaded outside the output state");

    a_write_window: assert property (@(posedge clk) disable iff (!rst_n)
        dly_we |-> ((state_reg == ST_FEED) || (state_reg == ST_OUT)))
        else $error("delay line written outside the feedback pass");

    a_div_window: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV))
        else $error("average finished outside its wait state");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        fb_vld_reg |-> !pipe_busy)
        else $error("feedback pass overlaps the tap pass");

endmodule

// ===== rtl/fdnr_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module fdnr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/fdnr_avg.sv =====
// Floor average of the damped taps: sum divided by the line count.
// Shift for a power-of-two count, else one restoring quotient bit per cycle.
// Depends on fdnr_pkg.
`timescale 1ns / 1ps

module fdnr_avg
    import fdnr_pkg::*;
#(
    parameter int LINE_COUNT  = DEF_LINE_COUNT,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic signed [SAMPLE_BITS+2:0] sum,
    output logic signed [SAMPLE_BITS-1:0] avg,
    output logic                          done
);

    localparam int S     = SAMPLE_BITS;
    localparam int SUM_W = S + 3;

    generate
        if ((LINE_COUNT & (LINE_COUNT - 1)) == 0)
        begin : g_shift
            localparam int LOG_N = $clog2(LINE_COUNT);
            logic signed [SUM_W-1:0] shifted;
            logic signed [S-1:0]     avg_reg;
            logic                    done_reg;

            assign shifted = sum >>> LOG_N;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    done_reg <= 1'b0;
                end
                else
                begin
                    done_reg <= start;
                end
            end

            always_ff @(posedge clk)
            begin
                if (start)
                begin
                    avg_reg <= shifted[S-1:0];
                end
            end

            assign avg  = avg_reg;
            assign done = done_reg;
        end
        else
        begin : g_serial
            localparam int REM_W = $clog2(LINE_COUNT) + 1;
            localparam int CNT_W = $clog2(S + 1);
            localparam logic [SUM_W-1:0] OFFSET = SUM_W'(LINE_COUNT) << (S - 1);

            logic [SUM_W-1:0] biased;
            logic [REM_W:0]   trial;
            logic             fits;
            logic [REM_W-1:0] rem_reg;
            logic [S-1:0]     quo_reg;
            logic [CNT_W-1:0] cnt_reg;
            logic             busy_reg;
            logic             done_reg;

            // bias to non-negative; the bias is a multiple of the count
            assign biased = $unsigned(sum) + OFFSET;
            assign trial  = {rem_reg, quo_reg[S-1]};
            assign fits   = trial >= (REM_W + 1)'(LINE_COUNT);

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b0;
                    cnt_reg  <= '0;
                end
                else
                begin
                    done_reg <= 1'b0;
                    if (start)
                    begin
                        busy_reg <= 1'b1;
                        cnt_reg  <= '0;
                    end
                    else if (busy_reg)
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                        if (cnt_reg == CNT_W'(S - 1))
                        begin
                            busy_reg <= 1'b0;
                            done_reg <= 1'b1;
                        end
                    end
                end
            end

            always_ff @(posedge clk)
            begin
                if (start)
                begin
                    rem_reg <= REM_W'(biased[SUM_W-1:S]);
                    quo_reg <= biased[S-1:0];
                end
                else if (busy_reg)
                begin
                    rem_reg <= fits ? REM_W'(trial - (REM_W + 1)'(LINE_COUNT))
                                    : trial[REM_W-1:0];
                    quo_reg <= {quo_reg[S-2:0], fits};
                end
            end

            // remove the bias: quotient minus 2^(S-1)
            assign avg  = $signed({~quo_reg[S-1], quo_reg[S-2:0]});
            assign done = done_reg;
        end
    endgenerate

endmodule

// ===== verif/tb_feedback_delay_network_reverb.sv =====
// Self-checking testbench for feedback_delay_network_reverb: streams dry samples
// in, predicts each mixed sample in SystemVerilog and compares on the output side.
// Depends on fdnr_pkg and the RTL top level; APB registers are written while idle.
`timescale 1ns / 1ps

module tb_feedback_delay_network_reverb;
    import fdnr_pkg::*;

    localparam int DATA_W      = ((DEF_SAMPLE_BITS + 7) / 8) * 8;
    localparam int LINES       = 8;
    localparam int DEPTH       = 32768;
    localparam int NUM_REGS    = 6;
    localparam int STALL_LIMIT = 3000;
    localparam int DRAIN_WAIT  = 40;

    localparam logic [REG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    localparam int REG_BITS [NUM_REGS] = '{16, 16, 24, 24, 24, 24};
    localparam int DELAY_LEN [LINES] = '{
        10691, 11777, 12983, 14197, 15401, 16573, 17749, 18947
    };
    localparam logic [23:0] CORNER_SAMPLES [10] = '{
        24'h7FFFFF, 24'h800000, 24'h000000, 24'hFFFFFF, 24'h000001,
        24'h555555, 24'hAAAAAA, 24'h7FFFFF, 24'h800000, 24'h400000
    };

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [DATA_W-1:0] s_tdata = '0;      // in_sample
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [DATA_W-1:0] m_tdata;           // out_sample
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [APB_W-1:0]  pwdata = '0;
    logic [APB_W-1:0]  prdata;
    logic              pready;

    // reverb state as the block should hold it
    int          delay_line [LINES][DEPTH];
    int          damp_z1 [LINES];
    int          damp_z2 [LINES];
    int          wr_ptr;
    logic [31:0] cfg_reg [NUM_REGS];

    logic [DATA_W-1:0] dry_samples [$];
    logic [DATA_W-1:0] expected_out [$];
    logic [DATA_W-1:0] want;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int mismatches = 0;
    int samples_sent = 0;
    int results_checked = 0;
    int stall_cycles = 0;

    feedback_delay_network_reverb i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    function automatic longint round_shift(longint v, int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint clip(longint v, int w);
        longint hi;
        longint lo;
        hi = (longint'(1) << (w - 1)) - 1;
        lo = -hi - 1;
        return (v > hi) ? hi : ((v < lo) ? lo : v);
    endfunction

    function automatic longint unity_clamp(logic [31:0] r);
        longint g;
        g = longint'(r[15:0]);
        return (g > 32768) ? 32768 : g;
    endfunction

    // one reverb step: damped taps, average, line write-back, wet/dry mix
    function automatic logic [DATA_W-1:0] reverb_sample(logic [DATA_W-1:0] din);
        longint x_in;
        longint b0;
        longint b1;
        longint a1;
        longint a2;
        longint wet;
        longint fbg;
        longint x;
        longint y;
        longint fx0;
        longint n1;
        longint n2;
        longint sum;
        longint avg;
        longint w;
        longint mix;
        longint taps [LINES];
        int     rp;
        x_in = longint'($signed(din[23:0]));
        b0   = longint'($signed(cfg_reg[REG_DAMP_B0][23:0]));
        b1   = longint'($signed(cfg_reg[REG_DAMP_B1][23:0]));
        a1   = longint'($signed(cfg_reg[REG_DAMP_A1][23:0]));
        a2   = longint'($signed(cfg_reg[REG_DAMP_A2][23:0]));
        wet  = unity_clamp(cfg_reg[REG_WET_MIX]);
        fbg  = unity_clamp(cfg_reg[REG_FEEDBACK_GAIN]);
        sum  = 0;
        for (int i = 0; i < LINES; i++)
        begin
            rp  = (wr_ptr + DEPTH - DELAY_LEN[i]) % DEPTH;
            x   = longint'(delay_line[i][rp]);
            fx0 = round_shift(b0 * x, 22);
            y   = clip(fx0 + longint'(damp_z1[i]), 24);
            n1  = clip(round_shift(b1 * x, 22) - round_shift(a1 * y, 22)
                       + longint'(damp_z2[i]), 32);
            n2  = clip(fx0 - round_shift(a2 * y, 22), 32);
            damp_z1[i] = int'(n1);
            damp_z2[i] = int'(n2);
            taps[i] = y;
            sum += y;
        end
        avg = sum >>> $clog2(LINES);
        for (int i = 0; i < LINES; i++)
        begin
            w = clip(x_in + round_shift((taps[i] - avg) * fbg, 15), 24);
            delay_line[i][wr_ptr] = int'(w);
        end
        wr_ptr = (wr_ptr + 1) % DEPTH;
        mix = clip(round_shift(x_in * (32768 - wet) + avg * wet, 15), 24);
        return DATA_W'(mix[23:0]);
    endfunction

    function automatic logic [DATA_W-1:0] random_sample();
        case ($urandom_range(9))
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            2, 3: return 24'($signed($urandom_range(8191)) - 4096);
            default: return 24'($urandom());
        endcase
    endfunction

    task automatic report_mismatch(string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    task automatic apb_transfer(logic wr, logic [REG_IDX_W-1:0] idx, logic [31:0] wdata,
                                output logic [31:0] rdata);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= PADDR_W'({idx, 2'b00});
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // upper pwdata bits carry junk; only the register's width is kept
    task automatic set_register(logic [REG_IDX_W-1:0] idx, logic [31:0] value);
        logic [31:0] mask;
        logic [31:0] rd;
        mask = (idx < NUM_REGS) ? ((32'h1 << REG_BITS[idx]) - 1) : 32'h0;
        apb_transfer(1'b1, idx, ($urandom() & ~mask) | (value & mask), rd);
        if (idx < NUM_REGS)
        begin
            cfg_reg[idx] = value & mask;
            apb_transfer(1'b0, idx, 32'h0, rd);
            if ((rd & mask) !== cfg_reg[idx])
                report_mismatch($sformatf("reg %0d read %h, wrote %h", idx, rd & mask,
                                          cfg_reg[idx]));
        end
    endtask

    task automatic pick_settings();
        set_register(REG_WET_MIX, ($urandom_range(3) == 0) ? $urandom_range(65535, 32769)
                                                           : $urandom_range(32768));
        set_register(REG_FEEDBACK_GAIN, ($urandom_range(3) == 0) ? $urandom_range(65535)
                                                                 : $urandom_range(32768, 16000));
        if ($urandom_range(3) == 0)
        begin
            set_register(REG_DAMP_B0, $urandom());
            set_register(REG_DAMP_B1, $urandom());
            set_register(REG_DAMP_A1, $urandom());
            set_register(REG_DAMP_A2, $urandom());
        end
        else
        begin
            set_register(REG_DAMP_B0, 32'(RST_DAMP_B0 + 24'($urandom_range(8000)) - 24'd4000));
            set_register(REG_DAMP_B1, 32'(RST_DAMP_B1 + 24'($urandom_range(8000)) - 24'd4000));
            set_register(REG_DAMP_A1, 32'(RST_DAMP_A1 + 24'($urandom_range(8000)) - 24'd4000));
            set_register(REG_DAMP_A2, 32'(RST_DAMP_A2 + 24'($urandom_range(8000)) - 24'd4000));
        end
    endtask

    task automatic queue_random(int n);
        repeat (n) dry_samples.push_back(random_sample());
    endtask

    task automatic wait_idle();
        while (dry_samples.size() != 0 || s_tvalid || expected_out.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                expected_out.push_back(reverb_sample(s_tdata));
                samples_sent++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (dry_samples.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= dry_samples.pop_front();
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                results_checked++;
                if (expected_out.size() == 0)
                    report_mismatch($sformatf("out_sample %h with nothing pending", m_tdata));
                else
                begin
                    want = expected_out.pop_front();
                    if (m_tdata !== want)
                        report_mismatch($sformatf("out_sample %h, expected %h", m_tdata, want));
                end
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stall_cycles <= 0;
            else if (stall_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
                $display("FAILURE");
                $finish;
            end
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    initial
    begin
        logic [31:0] rd;
        wr_ptr = 0;
        cfg_reg[REG_WET_MIX]       = 32'(RST_WET_MIX);
        cfg_reg[REG_FEEDBACK_GAIN] = 32'(RST_FEEDBACK_GAIN);
        cfg_reg[REG_DAMP_B0]       = 32'(RST_DAMP_B0);
        cfg_reg[REG_DAMP_B1]       = 32'(RST_DAMP_B1);
        cfg_reg[REG_DAMP_A1]       = 32'(RST_DAMP_A1);
        cfg_reg[REG_DAMP_A2]       = 32'(RST_DAMP_A2);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < NUM_REGS; i++)
        begin
            apb_transfer(1'b0, REG_IDX_W'(i), 32'h0, rd);
            if ((rd & ((32'h1 << REG_BITS[i]) - 1)) !== cfg_reg[i])
                report_mismatch($sformatf("reg %0d reset value %h", i, rd));
        end

        // corner samples at reset settings, dry only, then fully wet with gains over unity
        foreach (CORNER_SAMPLES[i]) dry_samples.push_back(CORNER_SAMPLES[i]);
        wait_idle();
        set_register(REG_WET_MIX, 32'h0);
        set_register(REG_FEEDBACK_GAIN, 32'h0);
        for (int i = 0; i < 4; i++) dry_samples.push_back(CORNER_SAMPLES[i]);
        wait_idle();
        set_register(REG_WET_MIX, 32'hFFFF);
        set_register(REG_FEEDBACK_GAIN, 32'hFFFF);
        set_register(REG_DAMP_B0, 32'h800000);
        set_register(REG_DAMP_B1, 32'h7FFFFF);
        set_register(REG_DAMP_A1, 32'h800000);
        set_register(REG_DAMP_A2, 32'h7FFFFF);
        set_register(REG_SPARE_LO, $urandom());
        set_register(REG_SPARE_HI, $urandom());
        for (int i = 4; i < 8; i++) dry_samples.push_back(CORNER_SAMPLES[i]);
        wait_idle();

        send_idle_pct = 23;
        recv_idle_pct = 77;
        pick_settings();
        queue_random(300);
        wait_idle();

        send_idle_pct = 77;
        recv_idle_pct = 23;
        pick_settings();
        queue_random(300);
        wait_idle();

        // long unstalled stretch so the two shortest taps see written history; the pointer wraps only in the later runs
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_register(REG_WET_MIX, 32'(RST_WET_MIX));
        set_register(REG_FEEDBACK_GAIN, 32'(UNITY_GAIN));
        set_register(REG_DAMP_B0, 32'(RST_DAMP_B0));
        set_register(REG_DAMP_B1, 32'(RST_DAMP_B1));
        set_register(REG_DAMP_A1, 32'(RST_DAMP_A1));
        set_register(REG_DAMP_A2, 32'(RST_DAMP_A2));
        queue_random(11500);
        wait_idle();

        set_register(REG_WET_MIX, 32'(UNITY_GAIN));
        set_register(REG_FEEDBACK_GAIN, 32'hFFFF);
        set_register(REG_DAMP_B0, 32'h7FFFFF);
        set_register(REG_DAMP_B1, 32'h800000);
        set_register(REG_DAMP_A1, 32'h7FFFFF);
        set_register(REG_DAMP_A2, 32'h800000);
        queue_random(300);
        wait_idle();

        repeat (4)
        begin
            pick_settings();
            queue_random(5200);
            wait_idle();
        end

        repeat (DRAIN_WAIT) @(posedge clk);
        if (expected_out.size() != 0)
            report_mismatch($sformatf("%0d output samples never arrived", expected_out.size()));

        $display("Sent %0d dry samples and checked %0d mixed samples across corner, stalled,",
                 samples_sent, results_checked);
        $display("saturating and pointer-wrapping settings; %0d mismatches", mismatches);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
